// File: sv/qalu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the quaternion ALU.
package qalu_pkg;

    typedef enum logic [2:0] {
        K_ADD   = 3'd0,
        K_SUB   = 3'd1,
        K_NEG   = 3'd2,
        K_MUL   = 3'd3,
        K_SCALE = 3'd4,
        K_DIV   = 3'd5,
        K_AXANG = 3'd6,
        K_NONE  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2,
        ST_RSV = 2'd3
    } t_status;

    localparam int TabLen = 24;
    localparam logic signed [35:0] CordicGain = 36'sd652032874;
    localparam logic signed [35:0] PiQ        = 36'sd3373259426;
    localparam logic signed [35:0] HalfPiQ    = 36'sd1686629713;
    localparam logic signed [35:0] TwoPiQ     = 36'sd6746518852;

    function automatic logic signed [35:0] atan_entry(input int i);
        logic signed [35:0] t;
        begin
            unique case (i)
                0: t = 36'sd843314856;
                1: t = 36'sd497837829;
                2: t = 36'sd263043836;
                3: t = 36'sd133525158;
                4: t = 36'sd67021686;
                5: t = 36'sd33543515;
                6: t = 36'sd16775850;
                7: t = 36'sd8388437;
                8: t = 36'sd4194282;
                9: t = 36'sd2097149;
                10: t = 36'sd1048575;
                11: t = 36'sd524287;
                12: t = 36'sd262143;
                13: t = 36'sd131071;
                14: t = 36'sd65535;
                15: t = 36'sd32767;
                16: t = 36'sd16383;
                17: t = 36'sd8191;
                18: t = 36'sd4095;
                19: t = 36'sd2047;
                20: t = 36'sd1023;
                21: t = 36'sd511;
                22: t = 36'sd255;
                23: t = 36'sd127;
                default: t = 36'sd0;
            endcase
            return t;
        end
    endfunction

endpackage

// File: sv/qalu_recip.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: round(2^(2F) / |d|), one quotient bit per stage.
module qalu_recip #(
    parameter int WORD_BITS = 24,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [WORD_BITS-1:0]        i_mag,
    output logic [2*FRAC_BITS+1:0]      o_quot
);
    localparam int QB = 2 * FRAC_BITS + 2;
    localparam int RB = WORD_BITS + 2;

    logic [QB-1:0]        r_num [QB+1];
    logic [QB-1:0]        r_q   [QB+1];
    logic [RB-1:0]        r_rem [QB+1];
    logic [WORD_BITS-1:0] r_d   [QB+1];

    // numerator = 2^(2F+1) + |d|, quotient of 2x form gives rounding
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= (QB'(1) << (2 * FRAC_BITS + 1)) + QB'(i_mag);
            r_q[0]   <= '0;
            r_rem[0] <= '0;
            r_d[0]   <= i_mag;
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_st
        logic [RB-1:0] w_t;
        logic          w_ge;
        always_comb begin
            w_t  = {r_rem[s][RB-2:0], r_num[s][QB-1-s]};
            w_ge = w_t >= {2'b00, r_d[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1] <= r_num[s];
                r_d[s+1]   <= r_d[s];
                r_rem[s+1] <= w_ge ? w_t - {2'b00, r_d[s]} : w_t;
                r_q[s+1]   <= {r_q[s][QB-2:0], w_ge};
            end
        end
    end

    // num = 2^(2F+1)+d ; quotient/2 = floor((2^(2F)+d/2)/d)
    assign o_quot = r_q[QB] >> 1;
endmodule

// File: sv/quaternion_alu_core.sv
`timescale 1ns / 1ps
// Quaternion ALU top level: pipelined arithmetic with saturation and status.
// Data passes the divider chain first, then the CORDIC chain.
// Throughput: one transfer per cycle; the whole pipe advances when the output is free.
// Every stage is a register; a stall freezes all stages, so nothing is lost or repeated.
// Reset clears the stage valid bits only; payload registers are not reset.
module quaternion_alu_core #(
    parameter int WORD_BITS       = 24,
    parameter int FRAC_BITS       = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_kind,
    input  logic signed [WORD_BITS-1:0] i_a_w,
    input  logic signed [WORD_BITS-1:0] i_a_x,
    input  logic signed [WORD_BITS-1:0] i_a_y,
    input  logic signed [WORD_BITS-1:0] i_a_z,
    input  logic signed [WORD_BITS-1:0] i_b_w,
    input  logic signed [WORD_BITS-1:0] i_b_x,
    input  logic signed [WORD_BITS-1:0] i_b_y,
    input  logic signed [WORD_BITS-1:0] i_b_z,
    input  logic signed [WORD_BITS-1:0] i_scalar,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [WORD_BITS-1:0] o_r_w,
    output logic signed [WORD_BITS-1:0] o_r_x,
    output logic signed [WORD_BITS-1:0] o_r_y,
    output logic signed [WORD_BITS-1:0] o_r_z,
    output logic [1:0]                  o_status
);
    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int NIT = (TRIG_ITERATIONS < qalu_pkg::TabLen) ? TRIG_ITERATIONS
                                                              : qalu_pkg::TabLen;
    localparam int DL  = 2 * F + 3;        // divider latency
    localparam int PB  = 2 * W + 4;        // product/sum width
    localparam int AB  = 36;               // folded angle and cordic width
    localparam int NS  = DL + NIT + 7;     // total stages before output register
    localparam logic signed [PB-1:0] Hi = PB'((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [PB-1:0] Lo = -PB'(64'sd1 <<< (W - 1));

    // angle reduction: offset to a non-negative value, then subtract 2pi multiples
    localparam int     AW     = (W + 32 - F > 40) ? W + 32 - F : 40;
    localparam longint OffK   = ((64'sd1 <<< (W + 28 - F)) + qalu_pkg::TwoPiQ - 1)
                                / qalu_pkg::TwoPiQ;
    localparam longint RedMax = (64'sd1 <<< (W + 28 - F)) + qalu_pkg::PiQ
                                + OffK * qalu_pkg::TwoPiQ;
    localparam int     NR     = $clog2(RedMax / qalu_pkg::TwoPiQ + 1);
    localparam logic signed [AW-1:0] TwoPiA = AW'(qalu_pkg::TwoPiQ);
    localparam logic signed [AW-1:0] PiA    = AW'(qalu_pkg::PiQ);
    localparam logic signed [AW-1:0] OffA   = AW'(qalu_pkg::PiQ + OffK * qalu_pkg::TwoPiQ);
    localparam logic signed [AW-1:0] FoldHi = AW'(qalu_pkg::PiQ + qalu_pkg::HalfPiQ);
    localparam logic signed [AW-1:0] FoldLo = AW'(qalu_pkg::PiQ - qalu_pkg::HalfPiQ);

    typedef struct packed {
        logic [2:0]          kind;
        logic [4*W-1:0]      a;
        logic [4*W-1:0]      b;
        logic signed [W-1:0] sc;
    } t_item;

    logic en;
    logic r_vld [NS+1];
    t_item r_it [DL+1];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    function automatic logic signed [W-1:0] satw(input logic signed [PB-1:0] v,
                                                 output logic f);
        begin
            f = (v > Hi) || (v < Lo);
            return (v > Hi) ? Hi[W-1:0] : (v < Lo) ? Lo[W-1:0] : v[W-1:0];
        end
    endfunction

    // ---------------- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NS; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i <= NS; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // ---------------- stage 0 capture, divider delay line
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it[0] <= '{kind: i_kind, a: {i_a_w, i_a_x, i_a_y, i_a_z},
                         b: {i_b_w, i_b_x, i_b_y, i_b_z}, sc: i_scalar};
            for (int i = 1; i <= DL; i++) r_it[i] <= r_it[i-1];
        end
    end

    logic [W-1:0]   w_mag;
    logic [2*F+1:0] w_quot;
    assign w_mag = r_it[0].sc[W-1] ? W'(-r_it[0].sc) : W'(r_it[0].sc);

    qalu_recip #(.WORD_BITS(W), .FRAC_BITS(F)) u_recip (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (w_mag),
        .o_quot(w_quot)
    );

    // ---------------- stage A: operand select (factor k, reciprocal sat)
    t_item               r_ia;
    logic signed [W-1:0] r_k;
    logic                r_kf;
    logic                r_dz;
    always_ff @(posedge i_clk) begin
        logic signed [PB-1:0] rec;
        logic                 f;
        if (en) begin
            rec  = $signed({{(PB-2*F-2){1'b0}}, w_quot});
            if (r_it[DL].sc[W-1]) rec = -rec;
            r_ia <= r_it[DL];
            r_dz <= (r_it[DL].sc == '0);
            if (r_it[DL].kind == qalu_pkg::K_DIV) begin
                r_k  <= satw(rec, f);
                r_kf <= f;
            end else begin
                r_k  <= r_it[DL].sc;
                r_kf <= 1'b0;
            end
        end
    end

    // ---------------- stage B: products (16 hamilton / 4 scale) and angle setup
    logic signed [PB-1:0] r_p [16];
    t_item                r_ib;
    logic                 r_kfb, r_dzb;
    logic signed [AW-1:0] r_ang;
    always_ff @(posedge i_clk) begin
        logic signed [W-1:0] av [4];
        logic signed [W-1:0] bv [4];
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                av[i] = r_ia.a[(3-i)*W +: W];
                bv[i] = r_ia.b[(3-i)*W +: W];
            end
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    r_p[i*4+j] <= PB'(av[i]) * PB'((r_ia.kind == qalu_pkg::K_MUL)
                                                   ? bv[j] : r_k);
            r_ib  <= r_ia;
            r_kfb <= r_kf;
            r_dzb <= r_dz;
            r_ang <= (AW'(r_ia.sc) <<< (30 - F - 1)) + OffA;
        end
    end

    // ---------------- stage C: quaternion combine + rounding, angle reduction
    logic signed [W-1:0] r_q [4];
    logic                r_qf;
    t_item               r_ic;
    logic                r_dzc;
    logic signed [AW-1:0] r_red;
    always_ff @(posedge i_clk) begin
        logic signed [PB-1:0] s [4];
        logic signed [PB-1:0] rnd;
        logic signed [PB-1:0] a0, b0;
        logic                 f, fa;
        logic signed [AW-1:0] t;
        if (en) begin
            // a index i, b index j at r_p[i*4+j]
            s[0] = r_p[0] - r_p[5] - r_p[10] - r_p[15];
            s[1] = r_p[1] + r_p[4] + r_p[11] - r_p[14];
            s[2] = r_p[2] + r_p[8] + r_p[13] - r_p[7];
            s[3] = r_p[3] + r_p[12] + r_p[6] - r_p[9];
            fa = 1'b0;
            for (int i = 0; i < 4; i++) begin
                unique case (qalu_pkg::t_kind'(r_ib.kind))
                    qalu_pkg::K_ADD: rnd = PB'($signed(r_ib.a[(3-i)*W +: W]))
                                         + PB'($signed(r_ib.b[(3-i)*W +: W]));
                    qalu_pkg::K_SUB: rnd = PB'($signed(r_ib.a[(3-i)*W +: W]))
                                         - PB'($signed(r_ib.b[(3-i)*W +: W]));
                    qalu_pkg::K_NEG: rnd = -PB'($signed(r_ib.a[(3-i)*W +: W]));
                    qalu_pkg::K_MUL: rnd = (s[i] + (PB'(1) <<< (F - 1))) >>> F;
                    qalu_pkg::K_SCALE, qalu_pkg::K_DIV:
                        rnd = (r_p[i*4] + (PB'(1) <<< (F - 1))) >>> F;
                    default: rnd = '0;
                endcase
                r_q[i] <= satw(rnd, f);
                fa = fa | f;
            end
            r_qf  <= fa | ((r_ib.kind == qalu_pkg::K_DIV) & r_kfb);
            r_ic  <= r_ib;
            r_dzc <= r_dzb;
            // upper reduction steps; the two lowest follow in the next stage
            t = r_ang;
            for (int k = NR - 1; k >= 2; k--)
                if (t >= (TwoPiA <<< k)) t = t - (TwoPiA <<< k);
            r_red <= t;
        end
    end

    // ---------------- stage D: last reduction steps and fold
    logic signed [W-1:0] r_qd [4];
    logic                r_qfd, r_dzd, r_neg;
    t_item               r_id;
    logic signed [AB-1:0] r_fold;
    always_ff @(posedge i_clk) begin
        logic signed [AW-1:0] t;
        logic signed [AW-1:0] fd;
        logic                 ng;
        if (en) begin
            t = r_red;
            for (int k = 1; k >= 0; k--)
                if (k < NR && t >= (TwoPiA <<< k)) t = t - (TwoPiA <<< k);
            // t is angle/2 + pi in [0, 2pi)
            if (t > FoldHi) begin
                fd = t - TwoPiA;
                ng = 1'b1;
            end else if (t < FoldLo) begin
                fd = t;
                ng = 1'b1;
            end else begin
                fd = t - PiA;
                ng = 1'b0;
            end
            r_fold <= AB'(fd);
            r_neg  <= ng;
            r_qd   <= r_q;
            r_qfd  <= r_qf;
            r_dzd  <= r_dzc;
            r_id   <= r_ic;
        end
    end

    // ---------------- CORDIC stages, one iteration each
    logic signed [AB-1:0] r_cx [NIT+1];
    logic signed [AB-1:0] r_cy [NIT+1];
    logic signed [AB-1:0] r_cz [NIT+1];
    logic                 r_cn [NIT+1];
    logic signed [W-1:0]  r_cq [NIT+1][4];
    logic                 r_cf [NIT+1];
    logic                 r_cd [NIT+1];
    t_item                r_ci [NIT+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0] <= qalu_pkg::CordicGain;
            r_cy[0] <= '0;
            r_cz[0] <= r_fold;
            r_cn[0] <= r_neg;
            r_cq[0] <= r_qd;
            r_cf[0] <= r_qfd;
            r_cd[0] <= r_dzd;
            r_ci[0] <= r_id;
        end
    end

    for (genvar g = 0; g < NIT; g++) begin : g_cordic
        localparam logic signed [AB-1:0] Atan = qalu_pkg::atan_entry(g);
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_cz[g][AB-1]) begin
                    r_cx[g+1] <= r_cx[g] - (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] + (r_cx[g] >>> g);
                    r_cz[g+1] <= r_cz[g] - Atan;
                end else begin
                    r_cx[g+1] <= r_cx[g] + (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] - (r_cx[g] >>> g);
                    r_cz[g+1] <= r_cz[g] + Atan;
                end
                r_cn[g+1] <= r_cn[g];
                r_cq[g+1] <= r_cq[g];
                r_cf[g+1] <= r_cf[g];
                r_cd[g+1] <= r_cd[g];
                r_ci[g+1] <= r_ci[g];
            end
        end
    end

    // ---------------- stage E: sin * axis, cos sign
    logic signed [AB+W-1:0] r_m [3];
    logic signed [AB-1:0]   r_cos;
    logic signed [W-1:0]    r_eq [4];
    logic                   r_ef, r_ed;
    logic [2:0]             r_ek;
    always_ff @(posedge i_clk) begin
        logic signed [AB-1:0] sn;
        if (en) begin
            sn    = r_cn[NIT] ? -r_cy[NIT] : r_cy[NIT];
            r_cos <= r_cn[NIT] ? -r_cx[NIT] : r_cx[NIT];
            for (int i = 0; i < 3; i++)
                r_m[i] <= (AB+W)'(sn) * (AB+W)'($signed(r_ci[NIT].b[(2-i)*W +: W]));
            r_eq <= r_cq[NIT];
            r_ef <= r_cf[NIT];
            r_ed <= r_cd[NIT];
            r_ek <= r_ci[NIT].kind;
        end
    end

    // ---------------- output register
    always_ff @(posedge i_clk) begin
        logic signed [PB-1:0]   v;
        logic signed [AB+W-1:0] m;
        logic                   f, fa;
        logic signed [W-1:0]    res [4];
        logic [1:0]             st;
        if (en) begin
            fa = 1'b0;
            res = r_eq;
            st = r_ef ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK;
            if (r_ek == qalu_pkg::K_AXANG) begin
                v = PB'((r_cos + (AB'(1) <<< (30 - F - 1))) >>> (30 - F));
                res[0] = satw(v, f);
                fa = fa | f;
                for (int i = 0; i < 3; i++) begin
                    m = (r_m[i] + ((AB+W)'(1) <<< 29)) >>> 30;
                    res[i+1] = satw(PB'(m), f);
                    fa = fa | f;
                end
                st = fa ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK;
            end else if (r_ek == qalu_pkg::K_DIV && r_ed) begin
                for (int i = 0; i < 4; i++) res[i] = '0;
                st = qalu_pkg::ST_DZ;
            end
            o_r_w    <= res[0];
            o_r_x    <= res[1];
            o_r_y    <= res[2];
            o_r_z    <= res[3];
            o_status <= st;
        end
    end

    assign o_valid = r_vld[NS];

    // ---------------- assertions
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_r_w) && $stable(o_status))
        else $error("output changed during stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready does not follow output stage");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != qalu_pkg::ST_RSV)
        else $error("reserved status code");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == qalu_pkg::ST_DZ |-> o_r_w == '0 && o_r_x == '0)
        else $error("divide by zero result not zero");
endmodule
